>>> rtl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window maximum unit.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SAMPLE_W   = 32;
	localparam int WIN_CFG_W  = 7;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W      = $clog2(MAX_WINDOW);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CNT_W-1:0]           count_t;
	typedef logic [IDX_W-1:0]           index_t;

	// control handed from the sequencer to one cell
	typedef struct packed {
		logic advance;   // a sample transfer happens this cycle
		logic restart;   // cell takes the sample alone (no history)
	} cell_ctrl_t;

endpackage : swm_pkg
`default_nettype wire

>>> rtl/swm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the max chain: holds the maximum of the last (index + 1)
// samples, built from its left neighbor and the new sample.
// ----------------------------------------------------------------------------
module swm_cell
	import swm_pkg::*;
(
	input  wire        clk,
	input  cell_ctrl_t ctrl,
	input  sample_t    sample,
	input  sample_t    prev_max,
	output sample_t    cell_max
);

	sample_t max_q;

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			if (ctrl.restart || sample >= prev_max) begin
				max_q <= sample;
			end else begin
				max_q <= prev_max;
			end
		end
	end

	assign cell_max = max_q;

endmodule : swm_cell
`default_nettype wire

>>> rtl/sliding_window_maximum_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_maximum_unit
// Streaming maximum over the last window_size samples, computed in a chain
// of max cells.
// ----------------------------------------------------------------------------
//  channel   dir  tdata / data                  side band
//  s_axis    in   [31:0] sample                 tlast = end_of_stream
//  m_axis    out  [31:0] window_max             tlast = last_result
//  cfg       in   [6:0]  window_size            -
//
// One sample per clock while not stalled; a result is registered in the cycle after its sample.
// Cell i holds the max of the last i+1 samples; the result is one compare
// against a cell picked by the live window span, so no loop limits the rate.
// Reset clears the counters and the output valid flag and sets the window
// register to 1; the cells hold data that is never read before being
// rewritten. s_axis stalls only when the output register is full and
// m_axis_tready is low. cfg is always ready.
// ----------------------------------------------------------------------------
module sliding_window_maximum_unit
	import swm_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,

	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [WIN_CFG_W-1:0]  cfg_data,       // [6:0] window_size

	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
	input  wire                  s_axis_tlast,   // end_of_stream

	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	output logic [SAMPLE_W-1:0]  m_axis_tdata,   // [31:0] window_max
	output logic                 m_axis_tlast    // last_result
);

	logic [WIN_CFG_W-1:0] win_cfg_q;
	count_t               fill_q;      // samples since stream start, saturating
	count_t               span_q;      // samples still inside the live window
	logic                 out_valid_q;
	sample_t              out_max_q;
	logic                 out_last_q;

	count_t               win_eff;
	count_t               fill_next;
	count_t               span_next;
	logic [CNT_W:0]       span_inc;
	count_t               sel_full;
	index_t               sel;
	logic                 in_xfer;
	logic                 emit;
	sample_t              sample;
	sample_t              prev_pick;
	sample_t              result;

	sample_t              cell_max [MAX_WINDOW];
	cell_ctrl_t           cell_ctrl [MAX_WINDOW];

	assign cfg_ready     = 1'b1;
	assign sample        = sample_t'(s_axis_tdata);
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (win_cfg_q == '0) begin
			win_eff = count_t'(1);
		end else if (int'(win_cfg_q) > MAX_WINDOW) begin
			win_eff = count_t'(MAX_WINDOW);
		end else begin
			win_eff = count_t'(win_cfg_q);
		end
	end

	// live span grows by one and is clipped by the current window
	always_comb begin
		span_inc = {1'b0, span_q} + (CNT_W+1)'(1);
		if (span_inc > {1'b0, win_eff}) begin
			span_next = win_eff;
		end else begin
			span_next = span_inc[CNT_W-1:0];
		end
		fill_next = (int'(fill_q) >= MAX_WINDOW) ? fill_q : fill_q + count_t'(1);
		emit      = s_axis_tlast || (fill_next >= win_eff);
	end

	// result = max(sample, max of the span_next-1 older samples)
	assign sel_full  = span_next - count_t'(2);
	assign sel       = sel_full[IDX_W-1:0];
	assign prev_pick = cell_max[sel];

	always_comb begin
		if (span_next == count_t'(1) || sample >= prev_pick) begin
			result = sample;
		end else begin
			result = prev_pick;
		end
	end

	generate
		for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
			sample_t left_max;

			if (i == 0) begin : g_head
				assign left_max = sample;
				assign cell_ctrl[i] = '{advance: in_xfer, restart: 1'b1};
			end else begin : g_body
				assign left_max = cell_max[i-1];
				assign cell_ctrl[i] = '{advance: in_xfer, restart: (fill_q == '0)};
			end

			swm_cell u_cell (
				.clk      (clk),
				.ctrl     (cell_ctrl[i]),
				.sample   (sample),
				.prev_max (left_max),
				.cell_max (cell_max[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q <= WIN_CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			win_cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			span_q <= '0;
		end else if (in_xfer) begin
			if (s_axis_tlast) begin
				fill_q <= '0;
				span_q <= '0;
			end else begin
				fill_q <= fill_next;
				span_q <= span_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && emit) begin
			out_max_q  <= result;
			out_last_q <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_max_q;
	assign m_axis_tlast  = out_last_q;

	// live span never exceeds the samples seen since stream start
	a_span_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		span_q <= fill_q)
		else $error("window span larger than fill count");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_WINDOW)
		else $error("fill count beyond maximum window");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_axis_tlast |=> fill_q == '0 && span_q == '0)
		else $error("stream state not cleared after final sample");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && emit |=> m_axis_tvalid)
		else $error("result transfer not presented");

	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_axis_tlast |=> m_axis_tlast)
		else $error("final sample result not marked last");

endmodule : sliding_window_maximum_unit
`default_nettype wire
